@@ rtl/dctq_pkg.sv @@
// Package for the dual class task queue: operation, status and state codes.
// Used by the sequencer and the top level; depends on nothing.
package dctq_pkg;

   localparam logic [2:0] MODE_PUSH    = 3'd0;
   localparam logic [2:0] MODE_POP     = 3'd1;
   localparam logic [2:0] MODE_RESCHED = 3'd2;
   localparam logic [2:0] MODE_PROMOTE = 3'd3;
   localparam logic [2:0] MODE_QUERY   = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_QN,
      ST_QP,
      ST_QWAIT,
      ST_HEADP,
      ST_HEADN,
      ST_HEADW,
      ST_RESP
   } state_type;

endpackage

@@ rtl/dctq_ram.sv @@
// Generic simple dual port synchronous RAM with registered read.
// No dependencies.
module dctq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

@@ rtl/dual_class_task_queue_unit.sv @@
// Dual class task queue: linked lists of task entries in a link RAM and an
// entry RAM (id, type, again flag). Push, pop, reschedule and promote run
// through read, execute and head-read states; a query first walks both lists
// with one link read per queued entry. One item at a time; the result waits
// in an output register.
// Reset runs a pass that builds the free list and clears the again flags; no
// item is accepted meanwhile.
module dual_class_task_queue_unit #(
   parameter int POOL_SIZE = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_task_id,
   input  logic [7:0] req_task_type,
   input  logic       req_is_priority,
   input  logic       req_to_front,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic       rsp_found,
   output logic       rsp_priority_empty,
   output logic       rsp_normal_empty,
   output logic       rsp_pool_full,
   output logic [7:0] rsp_priority_head_id,
   output logic [7:0] rsp_priority_head_type,
   output logic       rsp_priority_head_again,
   output logic [7:0] rsp_normal_head_id,
   output logic [7:0] rsp_normal_head_type,
   output logic       rsp_normal_head_again
);
   import dctq_pkg::*;

   localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int CW = $clog2(POOL_SIZE + 1);
   localparam int EW = 17;

   state_type state_ff, state_in;
   logic [AW-1:0] free_head_ff, free_head_in, ph_ff, ph_in, pt_ff, pt_in;
   logic [AW-1:0] nh_ff, nh_in, nt_ff, nt_in;
   logic [CW-1:0] fc_ff, fc_in, pc_ff, pc_in, nc_ff, nc_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [2:0] mode_ff;
   logic [7:0] id_ff, type_ff;
   logic prio_ff, front_ff, found_ff, found_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] phid_ff, phid_in, phty_ff, phty_in, nhid_ff, nhid_in, nhty_ff, nhty_in;
   logic phag_ff, phag_in, nhag_ff, nhag_in;

   logic l_we, e_we;
   logic [AW-1:0] l_wa, l_ra, e_wa, e_ra;
   logic [AW-1:0] l_wd, l_rd;
   logic [EW-1:0] e_wd, e_rd;

   dctq_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_link (
      .clock(clock), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
   dctq_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_entry (
      .clock(clock), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));

   logic [AW-1:0] sel_head, sel_tail;
   logic [CW-1:0] sel_cnt;
   assign sel_head = prio_ff ? ph_ff : nh_ff;
   assign sel_tail = prio_ff ? pt_ff : nt_ff;
   assign sel_cnt  = prio_ff ? pc_ff : nc_ff;

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] a);
      logic [CW:0] s;
      s = {{(CW+1-AW){1'b0}}, a} + 1'b1;
      if (s == (CW+1)'(POOL_SIZE)) s = '0;
      return s[AW-1:0];
   endfunction

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= '0; fc_ff <= CW'(POOL_SIZE);
         ph_ff <= '0; pt_ff <= '0; pc_ff <= '0;
         nh_ff <= '0; nt_ff <= '0; nc_ff <= '0;
         walk_ff <= '0; cur_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_head_ff <= free_head_in; fc_ff <= fc_in;
         ph_ff <= ph_in; pt_ff <= pt_in; pc_ff <= pc_in;
         nh_ff <= nh_in; nt_ff <= nt_in; nc_ff <= nc_in;
         walk_ff <= walk_in; cur_ff <= cur_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff <= req_mode; id_ff <= req_task_id; type_ff <= req_task_type;
         prio_ff <= req_is_priority; front_ff <= req_to_front;
      end
      found_ff <= found_in; status_ff <= status_in;
      phid_ff <= phid_in; phty_ff <= phty_in; phag_ff <= phag_in;
      nhid_ff <= nhid_in; nhty_ff <= nhty_in; nhag_ff <= nhag_in;
   end

   // hold off new beats while a result still waits
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   // sequencer: read links/entries, modify, write back
   always_comb begin
      state_in = state_ff; rsp_valid_in = rsp_valid_ff;
      free_head_in = free_head_ff; fc_in = fc_ff;
      ph_in = ph_ff; pt_in = pt_ff; pc_in = pc_ff;
      nh_in = nh_ff; nt_in = nt_ff; nc_in = nc_ff;
      walk_in = walk_ff; cur_in = cur_ff;
      found_in = found_ff; status_in = status_ff;
      phid_in = phid_ff; phty_in = phty_ff; phag_in = phag_ff;
      nhid_in = nhid_ff; nhty_in = nhty_ff; nhag_in = nhag_ff;
      l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
      e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            l_we = 1'b1; l_wa = cur_ff; l_wd = nxt(cur_ff);
            e_we = 1'b1; e_wa = cur_ff; e_wd = '0;
            cur_in = nxt(cur_ff);
            if (cur_ff == AW'(POOL_SIZE - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) state_in = ST_READ;
         end
         ST_READ: begin
            // fetch the link of the entry the operation starts from
            if (mode_ff == MODE_PUSH) l_ra = free_head_ff;
            else if (mode_ff == MODE_PROMOTE) l_ra = nh_ff;
            else l_ra = sel_head;
            e_ra = sel_head;
            status_in = STATUS_DONE; found_in = 1'b0;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_HEADP;
            unique case (mode_ff)
               MODE_PUSH: begin
                  if (fc_ff == '0) status_in = STATUS_FULL;
                  else begin
                     free_head_in = l_rd; fc_in = fc_ff - 1'b1;
                     e_we = 1'b1; e_wa = free_head_ff; e_wd = {1'b0, type_ff, id_ff};
                     if (sel_cnt == '0) begin
                        if (prio_ff) begin ph_in = free_head_ff; pt_in = free_head_ff; end
                        else begin nh_in = free_head_ff; nt_in = free_head_ff; end
                     end else if (front_ff) begin
                        l_we = 1'b1; l_wa = free_head_ff; l_wd = sel_head;
                        if (prio_ff) ph_in = free_head_ff; else nh_in = free_head_ff;
                     end else begin
                        l_we = 1'b1; l_wa = sel_tail; l_wd = free_head_ff;
                        if (prio_ff) pt_in = free_head_ff; else nt_in = free_head_ff;
                     end
                     if (prio_ff) pc_in = pc_ff + 1'b1; else nc_in = nc_ff + 1'b1;
                  end
               end
               MODE_POP: begin
                  if (sel_cnt == '0) status_in = STATUS_EMPTY;
                  else begin
                     if (prio_ff) begin ph_in = l_rd; pc_in = pc_ff - 1'b1; end
                     else begin nh_in = l_rd; nc_in = nc_ff - 1'b1; end
                     e_we = 1'b1; e_wa = sel_head; e_wd = {1'b0, e_rd[15:0]};
                     l_we = 1'b1; l_wa = sel_head; l_wd = free_head_ff;
                     free_head_in = sel_head; fc_in = fc_ff + 1'b1;
                  end
               end
               MODE_RESCHED: begin
                  if (sel_cnt == '0) status_in = STATUS_EMPTY;
                  else begin
                     e_we = 1'b1; e_wa = sel_head; e_wd = {1'b1, e_rd[15:0]};
                     if (sel_cnt > CW'(1)) begin
                        l_we = 1'b1; l_wa = sel_tail; l_wd = sel_head;
                        if (prio_ff) begin ph_in = l_rd; pt_in = ph_ff; end
                        else begin nh_in = l_rd; nt_in = nh_ff; end
                     end
                  end
               end
               MODE_PROMOTE: begin
                  if (nc_ff == '0) status_in = STATUS_EMPTY;
                  else begin
                     nh_in = l_rd; nc_in = nc_ff - 1'b1;
                     if (pc_ff == '0) pt_in = nh_ff;
                     else begin l_we = 1'b1; l_wa = nh_ff; l_wd = ph_ff; end
                     ph_in = nh_ff; pc_in = pc_ff + 1'b1;
                  end
               end
               MODE_QUERY: begin
                  cur_in = nh_ff; walk_in = nc_ff; state_in = ST_QN;
               end
               default: ;
            endcase
         end
         ST_QN, ST_QP: begin
            // issue a read for the current walk entry
            if (walk_ff == '0) begin
               if (state_ff == ST_QN) begin
                  cur_in = ph_ff; walk_in = pc_ff; state_in = ST_QP;
               end else state_in = ST_HEADP;
            end else begin
               l_ra = cur_ff; e_ra = cur_ff;
               walk_in = walk_ff - 1'b1;
               state_in = ST_QWAIT;
               found_in = found_ff;
               status_in = {1'b0, state_ff == ST_QP};
            end
         end
         ST_QWAIT: begin
            // compare and follow the link
            if (e_rd[7:0] == id_ff) found_in = 1'b1;
            cur_in = l_rd;
            state_in = status_ff[0] ? ST_QP : ST_QN;
            status_in = STATUS_DONE;
         end
         ST_HEADP: begin
            e_ra = ph_ff; state_in = ST_HEADN;
         end
         ST_HEADN: begin
            e_ra = nh_ff;
            phid_in = (pc_ff != '0) ? e_rd[7:0] : '0;
            phty_in = (pc_ff != '0) ? e_rd[15:8] : '0;
            phag_in = (pc_ff != '0) & e_rd[16];
            state_in = ST_HEADW;
         end
         ST_HEADW: begin
            nhid_in = (nc_ff != '0) ? e_rd[7:0] : '0;
            nhty_in = (nc_ff != '0) ? e_rd[15:8] : '0;
            nhag_in = (nc_ff != '0) & e_rd[16];
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_found = found_ff;
   assign rsp_priority_empty = (pc_ff == '0);
   assign rsp_normal_empty = (nc_ff == '0);
   assign rsp_pool_full = (fc_ff == '0);
   assign rsp_priority_head_id = phid_ff;
   assign rsp_priority_head_type = phty_ff;
   assign rsp_priority_head_again = phag_ff;
   assign rsp_normal_head_id = nhid_ff;
   assign rsp_normal_head_type = nhty_ff;
   assign rsp_normal_head_again = nhag_ff;
endmodule

@@ test/tb_dual_class_task_queue_unit.sv @@
// Testbench for the dual class task queue unit: directed and random beats
// checked against a behavioral model of the three linked lists.
// Depends on dctq_pkg and dual_class_task_queue_unit.
`timescale 1ns / 1ps

module tb_dual_class_task_queue_unit;
   import dctq_pkg::*;

   localparam int POOL = 16;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_mode = MODE_PUSH;
   logic [7:0] req_task_id = '0;
   logic [7:0] req_task_type = '0;
   logic       req_is_priority = 1'b0;
   logic       req_to_front = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic       rsp_found, rsp_priority_empty, rsp_normal_empty, rsp_pool_full;
   logic [7:0] rsp_priority_head_id, rsp_priority_head_type;
   logic       rsp_priority_head_again;
   logic [7:0] rsp_normal_head_id, rsp_normal_head_type;
   logic       rsp_normal_head_again;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic       prio_empty;
      logic       norm_empty;
      logic       full;
      logic [7:0] p_id;
      logic [7:0] p_type;
      logic       p_again;
      logic [7:0] n_id;
      logic [7:0] n_type;
      logic       n_again;
   } snapshot_type;

   snapshot_type pending_snapshots[$];
   int        mismatch_count = 0;
   int        hold_off = 0;
   bit        no_idle = 1'b0;

   // shadow of the task pool
   logic [3:0] link_q[POOL];
   logic [7:0] ident_q[POOL];
   logic [7:0] kind_q[POOL];
   logic       again_q[POOL];
   logic [3:0] free_hd, p_hd, p_tl, n_hd, n_tl;
   int         free_cnt, p_cnt, n_cnt;

   dual_class_task_queue_unit #(.POOL_SIZE(POOL)) DUT (.*);

   always #4 clock = ~clock;

   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic void pool_reset();
      for (int i = 0; i < POOL; i++) begin
         link_q[i] = 4'((i + 1) % POOL);
         ident_q[i] = '0;
         kind_q[i] = '0;
         again_q[i] = 1'b0;
      end
      free_hd = '0; free_cnt = POOL;
      p_hd = '0; p_tl = '0; p_cnt = 0;
      n_hd = '0; n_tl = '0; n_cnt = 0;
   endfunction

   function automatic bit list_holds(logic [3:0] hd, int cnt, logic [7:0] id);
      logic [3:0] e;
      e = hd;
      for (int n = 0; n < cnt; n++) begin
         if (ident_q[e] == id) return 1'b1;
         e = link_q[e];
      end
      return 1'b0;
   endfunction

   // apply one operation to the shadow pool and return the head snapshot
   function automatic snapshot_type apply_task_op(logic [2:0] mode, logic [7:0] id,
         logic [7:0] kind, logic prio, logic front);
      snapshot_type s;
      logic [3:0] e, hd, tl;
      int cnt;
      s = '0;
      hd = prio ? p_hd : n_hd;
      tl = prio ? p_tl : n_tl;
      cnt = prio ? p_cnt : n_cnt;
      s.status = STATUS_DONE;
      case (mode)
         MODE_PUSH: begin
            if (free_cnt == 0) s.status = STATUS_FULL;
            else begin
               e = free_hd;
               free_hd = link_q[e];
               free_cnt--;
               ident_q[e] = id; kind_q[e] = kind; again_q[e] = 1'b0;
               if (cnt == 0) begin hd = e; tl = e; end
               else if (front) begin link_q[e] = hd; hd = e; end
               else begin link_q[tl] = e; tl = e; end
               cnt++;
            end
         end
         MODE_POP: begin
            if (cnt == 0) s.status = STATUS_EMPTY;
            else begin
               e = hd;
               hd = link_q[e];
               cnt--;
               again_q[e] = 1'b0;
               link_q[e] = free_hd;
               free_hd = e;
               free_cnt++;
            end
         end
         MODE_RESCHED: begin
            if (cnt == 0) s.status = STATUS_EMPTY;
            else begin
               e = hd;
               again_q[e] = 1'b1;
               if (cnt > 1) begin hd = link_q[e]; link_q[tl] = e; tl = e; end
            end
         end
         default: ;
      endcase
      if (mode inside {MODE_PUSH, MODE_POP, MODE_RESCHED}) begin
         if (prio) begin p_hd = hd; p_tl = tl; p_cnt = cnt; end
         else begin n_hd = hd; n_tl = tl; n_cnt = cnt; end
      end
      if (mode == MODE_PROMOTE) begin
         if (n_cnt == 0) s.status = STATUS_EMPTY;
         else begin
            e = n_hd;
            n_hd = link_q[e];
            n_cnt--;
            if (p_cnt == 0) p_tl = e;
            else link_q[e] = p_hd;
            p_hd = e;
            p_cnt++;
         end
      end
      if (mode == MODE_QUERY)
         s.found = list_holds(n_hd, n_cnt, id) || list_holds(p_hd, p_cnt, id);
      s.prio_empty = (p_cnt == 0);
      s.norm_empty = (n_cnt == 0);
      s.full = (free_cnt == 0);
      if (p_cnt != 0) begin
         s.p_id = ident_q[p_hd]; s.p_type = kind_q[p_hd]; s.p_again = again_q[p_hd];
      end
      if (n_cnt != 0) begin
         s.n_id = ident_q[n_hd]; s.n_type = kind_q[n_hd]; s.n_again = again_q[n_hd];
      end
      return s;
   endfunction

   // send one beat, idling first at random
   task automatic send_task_op(logic [2:0] mode, logic [7:0] id, logic [7:0] kind,
         logic prio, logic front);
      while (!no_idle && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_mode <= mode; req_task_id <= id; req_task_type <= kind;
      req_is_priority <= prio; req_to_front <= front;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_snapshots.push_back(apply_task_op(mode, id, kind, prio, front));
      @(negedge clock);
   endtask

   // drive response ready; honor a requested hold-off
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else rsp_ready <= no_idle || ($urandom_range(99) >= 25);
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      snapshot_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_found, rsp_priority_empty, rsp_normal_empty,
                rsp_pool_full, rsp_priority_head_id, rsp_priority_head_type,
                rsp_priority_head_again, rsp_normal_head_id, rsp_normal_head_type,
                rsp_normal_head_again};
         if (pending_snapshots.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected beat %h", got);
         end else begin
            want = pending_snapshots.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // drop valid and wait for every expected result
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_snapshots.size() != 0) @(negedge clock);
   endtask

   // extremes, empty-queue cases, unused modes
   task automatic test_directed();
      send_task_op(MODE_POP, 8'h00, 8'h00, 1'b0, 1'b0);
      send_task_op(MODE_POP, 8'h00, 8'h00, 1'b1, 1'b0);
      send_task_op(MODE_RESCHED, 8'h00, 8'h00, 1'b0, 1'b0);
      send_task_op(MODE_RESCHED, 8'h00, 8'h00, 1'b1, 1'b0);
      send_task_op(MODE_PROMOTE, 8'h00, 8'h00, 1'b1, 1'b1);
      send_task_op(MODE_QUERY, 8'h00, 8'h00, 1'b0, 1'b0);
      send_task_op(MODE_PUSH, 8'hFF, 8'h00, 1'b1, 1'b0);
      send_task_op(MODE_RESCHED, 8'h00, 8'h00, 1'b1, 1'b0);
      send_task_op(MODE_PUSH, 8'h00, 8'hFF, 1'b0, 1'b1);
      send_task_op(MODE_PUSH, 8'hA5, 8'h5A, 1'b0, 1'b0);
      send_task_op(MODE_PUSH, 8'h5A, 8'hA5, 1'b0, 1'b1);
      send_task_op(MODE_RESCHED, 8'h00, 8'h00, 1'b0, 1'b0);
      send_task_op(MODE_QUERY, 8'hFF, 8'h00, 1'b0, 1'b0);
      send_task_op(MODE_QUERY, 8'h77, 8'h00, 1'b1, 1'b1);
      send_task_op(MODE_PROMOTE, 8'h00, 8'h00, 1'b0, 1'b0);
      send_task_op(3'd5, 8'h12, 8'h34, 1'b1, 1'b1);
      send_task_op(3'd6, 8'h00, 8'h00, 1'b0, 1'b0);
      send_task_op(3'd7, 8'hFF, 8'hFF, 1'b1, 1'b0);
      send_task_op(MODE_POP, 8'h00, 8'h00, 1'b1, 1'b0);
   endtask

   // fill the pool while the receiver holds off, then reject, then drain
   task automatic test_full_pool();
      hold_off = 300;
      for (int i = 0; i < POOL + 2; i++)
         send_task_op(MODE_PUSH, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      send_task_op(MODE_QUERY, ident_q[n_cnt ? n_hd : p_hd], 8'h00, 1'b0, 1'b0);
      wait_drained();
      for (int i = 0; i < POOL + 2; i++)
         send_task_op(MODE_POP, 8'h00, 8'h00, 1'($urandom), 1'b0);
   endtask

   // random mix, biased by fill level so queues stay busy
   task automatic test_random(int count);
      logic [2:0] mode;
      int r;
      for (int i = 0; i < count; i++) begin
         no_idle = (i >= 600 && i < 800);
         r = $urandom_range(99);
         if (r < 4) mode = 3'($urandom_range(7, 5));
         else if (r < 35 + (free_cnt > 8 ? 15 : 0)) mode = MODE_PUSH;
         else if (r < 60) mode = MODE_POP;
         else if (r < 75) mode = MODE_RESCHED;
         else if (r < 85) mode = MODE_PROMOTE;
         else mode = MODE_QUERY;
         // about half of the queries look up a held id
         if (mode == MODE_QUERY && $urandom_range(1) && (n_cnt + p_cnt) > 0)
            send_task_op(mode, ident_q[n_cnt ? n_hd : p_hd], 8'($urandom), 1'($urandom),
                         1'($urandom));
         else
            send_task_op(mode, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
         if (i == 1000) wait_drained();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      pool_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_pool();
      test_random(1700);
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_snapshots.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
